// ----- hdl/assert_macros.svh -----
// Assertion macros for the sorter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- hdl/sksort_pkg.sv -----
// Package: shared types and constants of the score key entry sorter.
`timescale 1ns / 1ps
package sksort_pkg;
	localparam int unsigned MaxEntries = 64;
	localparam int unsigned KeyW = 32;
	localparam int unsigned CapW = 7;
	localparam logic [CapW-1:0] CapReset = 7'd64;
	localparam int unsigned OutDataW = 3 * KeyW;

	// Classified item passed from front to back end.
	typedef struct packed {
		logic [KeyW-1:0] key;
		logic [KeyW-1:0] ref_w;
		logic [KeyW-1:0] id;
		logic            keep;
		logic            last;
	} item_t;
endpackage

// ----- hdl/sksort_front.sv -----
// Front end: accepts items, applies the capacity limit, feeds the queue.
`timescale 1ns / 1ps
module sksort_front #(
	parameter int unsigned MAX_ENTRIES = sksort_pkg::MaxEntries
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [sksort_pkg::CapW-1:0] capacity,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [sksort_pkg::KeyW-1:0] in_key,
	input  logic [sksort_pkg::KeyW-1:0] in_ref,
	input  logic [sksort_pkg::KeyW-1:0] in_id,
	input  logic                        in_last,
	output logic                        q_valid,
	input  logic                        q_ready,
	output sksort_pkg::item_t           q_item
);
	localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned QD = 2;

	logic [CntW-1:0] count_q;
	logic [7:0] eff_cap;
	sksort_pkg::item_t fifo_q [QD];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;
	logic push, pop;

	// Effective capacity: zero reads as one, clamp to depth.
	always_comb begin
		eff_cap = {1'b0, capacity};
		if (eff_cap == 8'd0) eff_cap = 8'd1;
		if (eff_cap > 8'(MAX_ENTRIES)) eff_cap = 8'(MAX_ENTRIES);
	end

	assign in_ready = (fill_q != 2'(QD));
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;
	assign q_valid = (fill_q != 2'd0);
	assign q_item = fifo_q[rd_ptr_q];

	// Count of kept entries in the current batch.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			if (in_last) count_q <= '0;
			else if (8'(count_q) < eff_cap) count_q <= count_q + 1'b1;
		end
	end

	// Two-entry queue toward the back end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q].key <= in_key;
			fifo_q[wr_ptr_q].ref_w <= in_ref;
			fifo_q[wr_ptr_q].id <= in_id;
			fifo_q[wr_ptr_q].last <= in_last;
			fifo_q[wr_ptr_q].keep <= (8'(count_q) < eff_cap);
		end
	end
endmodule

// ----- hdl/sksort_back.sv -----
// Back end: insertion array of cells kept sorted, drained one per cycle while the receiver is ready.
`timescale 1ns / 1ps
module sksort_back #(
	parameter int unsigned MAX_ENTRIES = sksort_pkg::MaxEntries
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	output logic                            q_ready,
	input  sksort_pkg::item_t               q_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sksort_pkg::OutDataW-1:0] out_data,
	output logic                            out_last,
	output logic                            out_ovf,
	output logic                            draining
);
	localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned KW = sksort_pkg::KeyW;

	typedef enum logic {ST_LOAD, ST_DRAIN} state_t;

	state_t state_q;
	logic [KW-1:0] key_q [MAX_ENTRIES];
	logic [KW-1:0] ref_q [MAX_ENTRIES];
	logic [KW-1:0] id_q [MAX_ENTRIES];
	logic [CntW-1:0] n_q;
	logic drop_q;
	logic [MAX_ENTRIES-1:0] gt;
	logic [MAX_ENTRIES-1:0] gt_prev;
	logic take, ins, shift;

	assign q_ready = (state_q == ST_LOAD);
	assign take = q_valid && q_ready;
	assign ins = take && q_item.keep;
	assign out_valid = (state_q == ST_DRAIN) && (n_q != '0);
	assign shift = out_valid && out_ready;
	assign out_data = {id_q[0], ref_q[0], key_q[0]};
	assign out_last = (n_q == CntW'(1));
	assign out_ovf = drop_q;
	assign draining = (state_q == ST_DRAIN);

	// Cell i holds a key strictly above the new one (stable for equals).
	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++)
			gt[i] = (CntW'(i) < n_q) && (key_q[i] > q_item.key);
	end

	// Cell below moves up: true for every cell past the insert point, up to n.
	assign gt_prev = {gt[MAX_ENTRIES-2:0], 1'b0};

	// Sorted cell row: insert a new entry in place, or shift down on drain.
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (ins) begin
				if (gt_prev[i]) begin
					key_q[i] <= key_q[(i == 0) ? 0 : i - 1];
					ref_q[i] <= ref_q[(i == 0) ? 0 : i - 1];
					id_q[i] <= id_q[(i == 0) ? 0 : i - 1];
				end else if (gt[i] || CntW'(i) == n_q) begin
					key_q[i] <= q_item.key;
					ref_q[i] <= q_item.ref_w;
					id_q[i] <= q_item.id;
				end
			end else if (shift && i < MAX_ENTRIES - 1) begin
				key_q[i] <= key_q[i+1];
				ref_q[i] <= ref_q[i+1];
				id_q[i] <= id_q[i+1];
			end
		end
	end

	// Control: load until last, then drain the batch.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			n_q <= '0;
			drop_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (take) begin
						if (ins) n_q <= n_q + 1'b1;
						if (!q_item.keep) drop_q <= 1'b1;
						if (q_item.last) state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (n_q == '0) begin
						state_q <= ST_LOAD;
						drop_q <= 1'b0;
					end else if (shift) begin
						n_q <= n_q - 1'b1;
						if (out_last) begin
							state_q <= ST_LOAD;
							drop_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule

// ----- hdl/score_key_entry_sorter_core.sv -----
// An item is classified and registered in the front-end queue, then inserted into the
// sorted cell row from there; one item per cycle while loading.
// After the last item, results drain one per cycle while the receiver is ready;
// the back end stays in drain until the whole batch has been taken, and
// meanwhile the front-end queue fills with up to two items, then the input stalls.
// Reset (arst_n low, asynchronous) empties the batch and sets capacity to 64.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module score_key_entry_sorter_core #(
	parameter int unsigned MAX_ENTRIES = sksort_pkg::MaxEntries
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [6:0]   cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,  // score_key, entity_ref, entity_id
	input  logic         s_tlast,  // last_item
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,  // sorted_key, sorted_ref, sorted_id
	output logic         m_tlast,  // last_result
	output logic         m_tuser   // overflow
);
	logic [sksort_pkg::CapW-1:0] capacity_q;
	logic q_valid, q_ready, draining;
	sksort_pkg::item_t q_item;

	assign cfg_ready = 1'b1;

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) capacity_q <= sksort_pkg::CapReset;
		else if (cfg_valid) capacity_q <= cfg_data;
	end

	sksort_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
		.clk(clk), .arst_n(arst_n), .capacity(capacity_q),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_key(s_tdata[31:0]), .in_ref(s_tdata[63:32]), .in_id(s_tdata[95:64]),
		.in_last(s_tlast),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	sksort_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata),
		.out_last(m_tlast), .out_ovf(m_tuser), .draining(draining)
	);

	`ASSERT_NEVER(a_out_only_drain, clk, arst_n, m_tvalid && !draining)
	`ASSERT_NEVER(a_no_load_in_drain, clk, arst_n, q_ready && draining)
	`ASSERT_IMPL(a_last_ends_drain, clk, arst_n, (m_tvalid && m_tready && m_tlast) |=> !draining)
endmodule

// ----- sim/tb_top.sv -----
// Testbench for the score key entry sorter: directed and random batches checked against a stable-sort predictor.
`timescale 1ns / 1ps
class sort_board;
	bit [31:0] bkey[$];
	bit [31:0] bref[$];
	bit [31:0] bid[$];
	bit dropped;
	bit [6:0] cap;
	bit [31:0] exp_key[$];
	bit [31:0] exp_ref[$];
	bit [31:0] exp_id[$];
	bit exp_last[$];
	bit exp_ovf[$];
	int errors;

	function void reset_state();
		bkey.delete(); bref.delete(); bid.delete();
		dropped = 0;
		cap = 7'd64;
		errors = 0;
	endfunction

	function int eff_cap();
		int c;
		c = cap;
		if (c == 0) c = 1;
		if (c > 64) c = 64;
		return c;
	endfunction

	// Store the entry or drop it; on the last item emit a stable ascending order.
	function void note_entry(bit [31:0] k, bit [31:0] r, bit [31:0] d, bit lst);
		int n;
		int j;
		bit [31:0] tk, tr, td;
		if (bkey.size() < eff_cap()) begin
			bkey.push_back(k); bref.push_back(r); bid.push_back(d);
		end else begin
			dropped = 1;
		end
		if (!lst) return;
		n = bkey.size();
		for (int i = 1; i < n; i++) begin
			tk = bkey[i]; tr = bref[i]; td = bid[i];
			j = i;
			while (j > 0 && bkey[j-1] > tk) begin
				bkey[j] = bkey[j-1]; bref[j] = bref[j-1]; bid[j] = bid[j-1];
				j--;
			end
			bkey[j] = tk; bref[j] = tr; bid[j] = td;
		end
		for (int i = 0; i < n; i++) begin
			exp_key.push_back(bkey[i]); exp_ref.push_back(bref[i]);
			exp_id.push_back(bid[i]); exp_last.push_back(i == n - 1);
			exp_ovf.push_back(dropped);
		end
		bkey.delete(); bref.delete(); bid.delete();
		dropped = 0;
	endfunction

	function void check_result(bit [95:0] data, bit lst, bit ovf);
		bit [97:0] want;
		if (exp_key.size() == 0) begin
			$display("%0t: unexpected result actual=%h last=%b ovf=%b", $time, data, lst, ovf);
			errors++;
			return;
		end
		want = {exp_ovf.pop_front(), exp_last.pop_front(), exp_id.pop_front(),
			exp_ref.pop_front(), exp_key.pop_front()};
		if (want != {ovf, lst, data}) begin
			$display("%0t: mismatch expected=%h actual=%h", $time, want, {ovf, lst, data});
			errors++;
		end
	endfunction
endclass

module tb_top;
	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [6:0] cfg_data = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [95:0] s_tdata = 0;
	logic s_tlast = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [95:0] m_tdata;
	logic m_tlast;
	logic m_tuser;

	sort_board board = new();
	int send_idle = 0;
	int recv_stall = 0;
	int hold_off = 0;
	longint cycles = 0;

	score_key_entry_sorter_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Receiver: random stalls plus an optional long hold-off
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata, m_tlast, m_tuser);
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Valid stays up between back-to-back transfers; it drops only for idle gaps.
	task automatic send_entry(bit [31:0] k, bit [31:0] r, bit [31:0] d, bit lst);
		if ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {d, r, k};
		s_tlast <= lst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_entry(k, r, d, lst);
	endtask

	task automatic drain_wait();
		s_tvalid <= 0;
		while (board.exp_key.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_cap(bit [6:0] v);
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		board.cap = v;
	endtask

	function automatic bit [31:0] rand_key();
		case ($urandom_range(3))
			0: return $urandom_range(7);
			1: return $urandom;
			default: return $urandom & 32'h7FFF_FFFF;
		endcase
	endfunction

	task automatic random_batch(int len);
		for (int i = 0; i < len; i++)
			send_entry(rand_key(), $urandom, $urandom, i == len - 1);
	endtask

	initial begin
		board.reset_state();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: extremes, ties, sign-bit keys, single entry
		send_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_entry(32'h0, 32'h0, 32'h0, 0);
		send_entry(32'h3F80_0000, 1, 2, 0);
		send_entry(32'h3F80_0000, 3, 4, 0);
		send_entry(32'h7FC0_0000, 5, 6, 0);
		send_entry(32'h8000_0000, 7, 8, 1);
		send_entry(32'h1234_5678, 9, 10, 1);
		drain_wait();
		// Capacity zero acts as one; final entry dropped
		write_cap(7'd0);
		send_entry(5, 1, 1, 0);
		send_entry(3, 2, 2, 1);
		drain_wait();
		// Above the maximum saturates; fill past 64
		write_cap(7'd127);
		random_batch(66);
		drain_wait();
		write_cap(7'd64);
		random_batch(64);
		drain_wait();
		write_cap(7'd3);
		random_batch(5);
		drain_wait();
		// Random phases over several idling profiles and capacities
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 74; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 74; end
				default: begin send_idle = 7; recv_stall = 7; end
			endcase
			write_cap(ph == 1 ? 7'd1 : (ph == 2 ? 7'd8 : 7'd64));
			for (int b = 0; b < 10; b++)
				random_batch($urandom_range(1, 10));
			if (ph == 0) begin
				hold_off = 300;
				random_batch(40);
			end
			drain_wait();
		end
		while (board.exp_key.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (board.errors == 0 && board.bkey.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+hdl
hdl/sksort_pkg.sv
hdl/sksort_front.sv
hdl/sksort_back.sv
hdl/score_key_entry_sorter_core.sv
sim/tb_top.sv
